FILE: hdl/citc_pkg.sv
// Shared types and constants of the ignition timing controller.
package citc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_OVERFLOW = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_SLOTS_LO  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SLOTS_MID = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOTS_HI  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHIFT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OVER_HIGH = 3'd4;

  localparam int unsigned TableSlots = 11;

  // One item waiting in the queue between the front and the back.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] period;
  } item_t;

endpackage

FILE: hdl/cdi_ignition_timing_controller_core.sv
// Top level of the ignition timing controller.
// Each item is taken into a two-entry queue by the front part and executed
// by the back part, one item at a time, with its single result then held on
// the output until taken. A delay tick, overflow or ordinary sample goes
// straight to the output; a locking sample first scans the ring; a sample
// that fires runs the serial ring sum, the shared 48-step restoring divider
// (speed, then any delay target) and the slot-by-slot table walk.
// Configuration registers are written through a plain write port; the user
// must write them only while the block is idle, which the block does not enforce.
module cdi_ignition_timing_controller_core #(
  parameter int unsigned RING_SIZE        = 4,
  parameter int unsigned SENSE_ROUNDS     = 8,
  parameter int unsigned METER_HZ         = 62500,
  parameter int unsigned DELAY_HZ         = 100000,
  parameter int unsigned SPARKS_PER_REV   = 2,
  parameter int unsigned VALUE_FULL_SCALE = 255
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [citc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [citc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [15:0]                    period_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           front_coil_o,
  output logic                           back_coil_o,
  output logic [7:0]                     speed_rps_o,
  output logic                           locked_o,
  output logic                           delay_pending_o
);

  logic [63:0] slots_lo_q, slots_mid_q;
  logic [47:0] slots_hi_q;
  logic [7:0]  shift_q, over_high_q;
  logic        q_valid, q_ready;
  citc_pkg::item_t q_item;

  // Configuration registers, reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_lo_q <= '0; slots_mid_q <= '0; slots_hi_q <= '0;
      shift_q <= '0; over_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        citc_pkg::REG_SLOTS_LO:  slots_lo_q  <= cfg_data_i;
        citc_pkg::REG_SLOTS_MID: slots_mid_q <= cfg_data_i;
        citc_pkg::REG_SLOTS_HI:  slots_hi_q  <= cfg_data_i[47:0];
        citc_pkg::REG_SHIFT:     shift_q     <= cfg_data_i[7:0];
        citc_pkg::REG_OVER_HIGH: over_high_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  citc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .period_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  citc_back #(
    .RING_SIZE(RING_SIZE), .SENSE_ROUNDS(SENSE_ROUNDS), .METER_HZ(METER_HZ),
    .DELAY_HZ(DELAY_HZ), .SPARKS_PER_REV(SPARKS_PER_REV),
    .VALUE_FULL_SCALE(VALUE_FULL_SCALE)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .slots_lo_i(slots_lo_q), .slots_mid_i(slots_mid_q), .slots_hi_i(slots_hi_q),
    .shift_i(shift_q), .over_high_i(over_high_q),
    .out_valid_o, .out_ready_i, .front_coil_o, .back_coil_o, .speed_rps_o,
    .locked_o, .delay_pending_o
  );

endmodule

FILE: hdl/citc_front.sv
// Input stage: accepts items into a short queue.
module citc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [15:0]           period_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output citc_pkg::item_t       q_item_o
);

  citc_pkg::item_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].cmd    <= cmd_i;
      mem_q[wp_q].period <= period_i;
    end
  end

endmodule

FILE: hdl/citc_back.sv
// Execution stage: ring, lock search, speed divide, table lookup and delay.
module citc_back #(
  parameter int unsigned RING_SIZE        = 4,
  parameter int unsigned SENSE_ROUNDS     = 8,
  parameter int unsigned METER_HZ         = 62500,
  parameter int unsigned DELAY_HZ         = 100000,
  parameter int unsigned SPARKS_PER_REV   = 2,
  parameter int unsigned VALUE_FULL_SCALE = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  citc_pkg::item_t       q_item_i,
  input  logic [63:0]           slots_lo_i,
  input  logic [63:0]           slots_mid_i,
  input  logic [47:0]           slots_hi_i,
  input  logic [7:0]            shift_i,
  input  logic [7:0]            over_high_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  front_coil_o,
  output logic                  back_coil_o,
  output logic [7:0]            speed_rps_o,
  output logic                  locked_o,
  output logic                  delay_pending_o
);

  localparam int unsigned PosW  = $clog2(RING_SIZE);
  localparam int unsigned SumW  = 16 + $clog2(RING_SIZE + 1);
  localparam int unsigned RndW  = $clog2(SENSE_ROUNDS + 1);
  localparam int unsigned NumW  = 48;
  localparam int unsigned DivW  = 32;
  localparam logic [NumW-1:0] MeterK = NumW'(METER_HZ);
  localparam logic [23:0] DelayK = 24'(DELAY_HZ);
  localparam logic [23:0] ScaleK = 24'(SPARKS_PER_REV * VALUE_FULL_SCALE);
  localparam int unsigned CntW  = $clog2(NumW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_LOCK, S_DIV1, S_LOOK, S_DIV2, S_OUT
  } state_e;

  state_e state_q;
  logic [15:0]    ring_q [RING_SIZE];
  logic [PosW-1:0] pos_q, gap_q, idx_q;
  logic [RndW-1:0] rounds_q;
  logic           locked_q, busy_q, sel_q, armed_q, front_q, back_q;
  logic [7:0]     speed_q;
  logic [31:0]    target_q, count_q;
  logic [SumW-1:0] sum_q;
  logic [15:0]    least_q;
  logic [NumW-1:0] num_q, rem_q;
  logic [DivW-1:0] den_q;
  logic [CntW-1:0] bit_q;
  logic [3:0]     slot_q;
  logic           second_q;

  function automatic logic [15:0] slot_word(input logic [63:0] lo, input logic [63:0] mid,
                                            input logic [47:0] hi, input logic [3:0] k);
    logic [63:0] r;
    r = (k < 4'd4) ? lo : (k < 4'd8) ? mid : {16'd0, hi};
    return r[k[1:0]*16 +: 16];
  endfunction

  // One restoring division step.
  logic [NumW:0]   trial;
  logic [NumW-1:0] rem_sh;
  assign rem_sh = {rem_q[NumW-2:0], num_q[NumW-1]};
  assign trial  = {1'b0, rem_sh} - {{(NumW+1-DivW){1'b0}}, den_q};

  logic [15:0] sw_next, sw_cur;
  assign sw_next = slot_word(slots_lo_i, slots_mid_i, slots_hi_i, slot_q + 4'd1);
  assign sw_cur  = slot_word(slots_lo_i, slots_mid_i, slots_hi_i, slot_q);

  // Delay value of the slot under inspection; past the last bound the
  // over-high timing applies.
  logic [7:0] look_val;
  assign look_val = (32'(slot_q) + 32'd1 >= citc_pkg::TableSlots)
                    ? shift_i - over_high_i : shift_i - sw_cur[15:8];

  logic [PosW-1:0] pos_inc, sec_pos;
  logic [PosW:0]   sec_sum;
  assign pos_inc = (32'(pos_q) + 32'd1 >= RING_SIZE) ? '0 : pos_q + PosW'(1);
  assign sec_sum = {1'b0, gap_q} + (PosW+1)'(2);
  assign sec_pos = (32'(sec_sum) >= RING_SIZE) ? PosW'(32'(sec_sum) - RING_SIZE)
                                               : sec_sum[PosW-1:0];

  assign q_ready_o       = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign front_coil_o    = front_q;
  assign back_coil_o     = back_q;
  assign speed_rps_o     = locked_q ? speed_q : 8'd0;
  assign locked_o        = locked_q;
  assign delay_pending_o = armed_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i && q_item_i.cmd == citc_pkg::CMD_SAMPLE)
      ring_q[pos_q] <= q_item_i.period;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pos_q <= '0; gap_q <= '0; idx_q <= '0;
      rounds_q <= '0; locked_q <= 1'b0; busy_q <= 1'b0; sel_q <= 1'b0;
      armed_q <= 1'b0; front_q <= 1'b1; back_q <= 1'b1; speed_q <= '0;
      target_q <= '0; count_q <= '0; sum_q <= '0; least_q <= '0;
      num_q <= '0; rem_q <= '0; den_q <= '0; bit_q <= '0;
      slot_q <= '0; second_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          state_q <= S_OUT;
          unique case (citc_pkg::cmd_e'(q_item_i.cmd))
            citc_pkg::CMD_SAMPLE: begin
              pos_q <= pos_inc;
              if (locked_q) begin
                if (pos_q == gap_q || pos_q == sec_pos) begin
                  if (sel_q) back_q <= 1'b0; else front_q <= 1'b0;
                  if (!busy_q) begin
                    busy_q   <= 1'b1;
                    second_q <= (pos_q == sec_pos);
                    sum_q    <= '0;
                    idx_q    <= '0;
                    state_q  <= S_SUM;
                  end
                end
              end else if (32'(pos_q) + 32'd1 >= RING_SIZE) begin
                if (32'(rounds_q) + 32'd1 >= SENSE_ROUNDS) begin
                  rounds_q <= '0;
                  least_q  <= 16'hFFFF;
                  idx_q    <= '0;
                  state_q  <= S_LOCK;
                end else rounds_q <= rounds_q + RndW'(1);
              end
            end
            citc_pkg::CMD_OVERFLOW: begin
              rounds_q <= '0; locked_q <= 1'b0; front_q <= 1'b0; back_q <= 1'b0;
            end
            citc_pkg::CMD_TICK: if (armed_q) begin
              count_q <= count_q + 32'd1;
              if (count_q + 32'd1 >= target_q) begin
                armed_q <= 1'b0; busy_q <= 1'b0;
                if (sel_q) back_q <= 1'b1; else front_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_LOCK: begin
          if (ring_q[idx_q] < least_q) begin
            least_q <= ring_q[idx_q];
            gap_q   <= idx_q;
          end
          if (32'(idx_q) + 32'd1 >= RING_SIZE) begin
            locked_q <= 1'b1; state_q <= S_OUT;
          end else idx_q <= idx_q + PosW'(1);
        end
        S_SUM: begin
          sum_q <= sum_q + SumW'(ring_q[idx_q]);
          if (32'(idx_q) + 32'd1 >= RING_SIZE) begin
            state_q <= S_DIV1;
            num_q   <= MeterK;
            rem_q   <= '0;
            den_q   <= (sum_q + SumW'(ring_q[idx_q]) == '0) ? DivW'(1)
                       : DivW'(sum_q + SumW'(ring_q[idx_q]));
            bit_q   <= CntW'(NumW);
          end else idx_q <= idx_q + PosW'(1);
        end
        S_DIV1, S_DIV2: begin
          num_q <= {num_q[NumW-2:0], ~trial[NumW]};
          rem_q <= trial[NumW] ? rem_sh : trial[NumW-1:0];
          bit_q <= bit_q - CntW'(1);
          if (bit_q == CntW'(1)) begin
            if (state_q == S_DIV1) begin
              speed_q <= ({num_q[NumW-2:0], ~trial[NumW]} > NumW'(255)) ? 8'd255
                         : 8'({num_q[NumW-2:0], ~trial[NumW]});
              slot_q  <= '0;
              state_q <= S_LOOK;
            end else begin
              target_q <= 32'({num_q[NumW-2:0], ~trial[NumW]});
              count_q  <= '0;
              armed_q  <= 1'b1;
              state_q  <= S_OUT;
            end
          end
        end
        S_LOOK: begin
          // Walk the table one slot a cycle; stop at the first bound above speed.
          if (32'(slot_q) + 32'd1 >= citc_pkg::TableSlots || speed_q < sw_next[7:0]) begin
            sel_q <= ~second_q;
            if (look_val == 8'd0) begin
              busy_q <= 1'b0;
              if (!second_q) back_q <= 1'b1; else front_q <= 1'b1;
              state_q <= S_OUT;
            end else begin
              num_q   <= NumW'({8'd0, DelayK} * {24'd0, look_val});
              rem_q   <= '0;
              den_q   <= (speed_q == 8'd0) ? DivW'(1) : DivW'(32'(speed_q) * 32'(ScaleK));
              bit_q   <= CntW'(NumW);
              state_q <= S_DIV2;
            end
          end else slot_q <= slot_q + 4'd1;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/citc_checker.sv
// Port-level checks of the ignition timing controller.
module citc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] speed_rps_o,
  input logic       locked_o,
  input logic       front_coil_o
);

  a_speed_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !locked_o |-> speed_rps_o == 8'd0) else $error("speed shown while unlocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_rps_o))
    else $error("result changed while stalled");

  a_coil_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(front_coil_o))
    else $error("coil moved while a result was waiting");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule

bind cdi_ignition_timing_controller_core citc_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .speed_rps_o, .locked_o, .front_coil_o
);

FILE: verif/tb.sv
// Self-checking testbench for the ignition timing controller core.
module tb;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [citc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [citc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    cmd_i = citc_pkg::CMD_NONE;
  logic [15:0]                   period_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          front_coil_o;
  logic                          back_coil_o;
  logic [7:0]                    speed_rps_o;
  logic                          locked_o;
  logic                          delay_pending_o;

  // One predicted result of the block.
  typedef struct packed {
    logic       front;
    logic       back;
    logic [7:0] rps;
    logic       lock;
    logic       pending;
  } coil_state_t;

  cdi_ignition_timing_controller_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .period_i,
    .out_valid_o, .out_ready_i,
    .front_coil_o, .back_coil_o, .speed_rps_o, .locked_o, .delay_pending_o
  );

  // The clock runs with a period of 12 time units.
  always #6 clk_i = ~clk_i;

  // The ignition state held alongside the block, and its configuration.
  logic [63:0] slots_lo, slots_mid, slots_hi;
  logic [7:0]  shift_reg, over_high_reg;
  logic [15:0] ring [4];
  logic [1:0]  ring_at;
  int unsigned rounds;
  logic [1:0]  gap_at;
  logic        is_locked, is_busy, coil_sel, armed, front_lvl, back_lvl;
  logic [7:0]  rps_now;
  logic [31:0] delay_goal, delay_cnt;

  citc_pkg::item_t stim_q[$];
  coil_state_t     coil_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // Fetches the 16-bit table slot k from the three packed slot registers.
  function automatic logic [15:0] slot_word(int unsigned k);
    logic [63:0] r;
    r = (k < 4) ? slots_lo : (k < 8) ? slots_mid : slots_hi;
    return r[(k % 4) * 16 +: 16];
  endfunction

  // Walks the table for the first bound above the speed; the value wraps modulo 256.
  function automatic logic [7:0] advance_for(logic [7:0] rps);
    logic [15:0] nxt, cur;
    for (int unsigned i = 0; i + 1 < citc_pkg::TableSlots; i++) begin
      nxt = slot_word(i + 1);
      cur = slot_word(i);
      if (rps < nxt[7:0]) return shift_reg - cur[15:8];
    end
    return shift_reg - over_high_reg;
  endfunction

  function automatic void spark_now();
    armed = 1'b0;
    if (coil_sel) back_lvl = 1'b1;
    else front_lvl = 1'b1;
    is_busy = 1'b0;
  endfunction

  // Applies one item to the held state and returns the result it produces.
  function automatic coil_state_t ignition_step(citc_pkg::item_t it);
    coil_state_t r;
    logic [1:0]  pos, first, second;
    logic [31:0] sum;
    logic [31:0] quot;
    logic [7:0]  val;
    logic [63:0] div;
    logic [15:0] least;
    case (it.cmd)
      citc_pkg::CMD_SAMPLE: begin
        pos = ring_at;
        ring[pos] = it.period;
        if (is_locked) begin
          first = gap_at;
          second = gap_at + 2'd2;
          if (pos == first || pos == second) begin
            if (coil_sel) back_lvl = 1'b0;
            else front_lvl = 1'b0;
            if (!is_busy) begin
              is_busy = 1'b1;
              sum = 32'(ring[0]) + ring[1] + ring[2] + ring[3];
              if (sum == 0) sum = 1;
              quot = 32'd62500 / sum;
              rps_now = (quot > 255) ? 8'd255 : quot[7:0];
              val = advance_for(rps_now);
              coil_sel = (pos == second) ? 1'b0 : 1'b1;
              if (val != 0) begin
                div = 64'(rps_now) * 2 * 255;
                if (div == 0) div = 1;
                delay_goal = 32'((64'd100000 * val) / div);
                delay_cnt = 0;
                armed = 1'b1;
              end else begin
                spark_now();
              end
            end
          end
          ring_at = pos + 2'd1;
        end else begin
          ring_at = pos + 2'd1;
          if (pos == 2'd3) begin
            rounds++;
            if (rounds >= 8) begin
              rounds = 0;
              least = 16'hFFFF;
              for (int i = 0; i < 4; i++) begin
                if (ring[i] < least) begin
                  least = ring[i];
                  gap_at = 2'(i);
                end
              end
              is_locked = 1'b1;
            end
          end
        end
      end
      citc_pkg::CMD_OVERFLOW: begin
        rounds = 0;
        is_locked = 1'b0;
        front_lvl = 1'b0;
        back_lvl = 1'b0;
      end
      citc_pkg::CMD_TICK: begin
        if (armed) begin
          delay_cnt++;
          if (delay_cnt >= delay_goal) spark_now();
        end
      end
      default: ;
    endcase
    r.front = front_lvl;
    r.back = back_lvl;
    r.rps = is_locked ? rps_now : 8'd0;
    r.lock = is_locked;
    r.pending = armed;
    return r;
  endfunction

  // Sender: bursts of items with random gaps, each accepted item predicted at once.
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        coil_expect_q.push_back(ignition_step(stim_q[0]));
        stim_q.pop_front();
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (stim_q.size() > 0) begin
          in_valid_i <= 1'b1;
          cmd_i <= stim_q[0].cmd;
          period_i <= stim_q[0].period;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            gap_left = $urandom_range(0, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a rotating random mask, with one long hold-off so that
  // the block fills and stops taking items.
  typedef logic bool_t;
  logic [15:0] ready_mask = 16'hFFFF;
  int unsigned mask_age = 0;
  int unsigned hold_left = 0;
  bool_t       held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      held_once = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (coil_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: front %0b back %0b",
                                         front_coil_o, back_coil_o);
        end else begin
          if (coil_expect_q[0] !== {front_coil_o, back_coil_o, speed_rps_o, locked_o,
                                     delay_pending_o}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected front %0b back %0b rps %0d lock %0b pend %0b, got front %0b back %0b rps %0d lock %0b pend %0b",
                       coil_expect_q[0].front, coil_expect_q[0].back, coil_expect_q[0].rps,
                       coil_expect_q[0].lock, coil_expect_q[0].pending, front_coil_o,
                       back_coil_o, speed_rps_o, locked_o, delay_pending_o);
          end
          coil_expect_q.pop_front();
        end
      end
      if (!held_once && results_seen == 150) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      mask_age++;
      if (mask_age >= 64) begin
        mask_age = 0;
        ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      ready_mask = {ready_mask[14:0], ready_mask[15]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ready_mask[0];
      end
    end
  end

  // Register writes happen only while the block has nothing in flight.
  task automatic write_reg(logic [citc_pkg::CfgIdxW-1:0] idx,
                           logic [citc_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      citc_pkg::REG_SLOTS_LO:  slots_lo = data;
      citc_pkg::REG_SLOTS_MID: slots_mid = data;
      citc_pkg::REG_SLOTS_HI:  slots_hi = {16'h0, data[47:0]};
      citc_pkg::REG_SHIFT:     shift_reg = data[7:0];
      citc_pkg::REG_OVER_HIGH: over_high_reg = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Chooses a setting: zero table and shift, all ones, or a rising table (wrapping
  // at 256) whose timings sit just under the shift, which keeps spark delays short.
  task automatic configure(int unsigned mode);
    logic [63:0] w [3];
    logic [7:0]  sh, bnd;
    sh = 8'($urandom);
    bnd = 8'd0;
    for (int k = 0; k < 11; k++) begin
      bnd = bnd + 8'($urandom_range(0, 30));
      w[k / 4][(k % 4) * 16 +: 16] = {sh - 8'($urandom_range(0, 6)), bnd};
    end
    if (mode == 0) begin
      w = '{default: 64'h0};
      sh = 8'h00;
    end else if (mode == 1) begin
      w = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
      sh = 8'hFF;
    end
    write_reg(citc_pkg::REG_SLOTS_LO, w[0]);
    write_reg(citc_pkg::REG_SLOTS_MID, w[1]);
    write_reg(citc_pkg::REG_SLOTS_HI, w[2]);
    write_reg(citc_pkg::REG_SHIFT, {56'h0, sh});
    write_reg(citc_pkg::REG_OVER_HIGH,
              (mode == 1) ? 64'hFF : {56'h0, sh - 8'($urandom_range(0, 4))});
  endtask

  task automatic add_item(citc_pkg::cmd_e c, logic [15:0] p);
    stim_q.push_back('{cmd: c, period: p});
  endtask

  // Mostly short periods so the engine looks fast; now and then any 16-bit value.
  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(20, 400));
    endcase
  endfunction

  task automatic drain();
    wait (stim_q.size() == 0 && !in_valid_i && coil_expect_q.size() == 0);
    // Let the last handshake settle before the setting changes.
    repeat (200) @(posedge clk_i);
  endtask

  int unsigned queued;
  int unsigned n;
  initial begin
    slots_lo = '0; slots_mid = '0; slots_hi = '0; shift_reg = '0; over_high_reg = '0;
    ring = '{default: 16'h0};
    ring_at = '0; rounds = 0; gap_at = '0; is_locked = 0; is_busy = 0; coil_sel = 0;
    armed = 0; front_lvl = 1; back_lvl = 1; rps_now = '0; delay_goal = '0; delay_cnt = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed start: idle tick, unused command, then a lock on a tied shortest
    // gap, firing at both trigger positions, overflow while a delay is armed,
    // a lock onto an all-zero ring and one where every entry is at full scale.
    configure(2);
    add_item(citc_pkg::CMD_TICK, 16'h0);
    add_item(citc_pkg::CMD_NONE, 16'hFFFF);
    for (int i = 0; i < 32; i++) add_item(citc_pkg::CMD_SAMPLE, (i % 2) ? 16'd90 : 16'd40);
    for (int i = 0; i < 8; i++) add_item(citc_pkg::CMD_SAMPLE, 16'd40);
    for (int i = 0; i < 40; i++) add_item(citc_pkg::CMD_TICK, 16'h0);
    add_item(citc_pkg::CMD_SAMPLE, 16'd30);
    add_item(citc_pkg::CMD_OVERFLOW, 16'h0);
    for (int i = 0; i < 32; i++) add_item(citc_pkg::CMD_SAMPLE, 16'h0);
    for (int i = 0; i < 6; i++) add_item(citc_pkg::CMD_SAMPLE, 16'h0);
    add_item(citc_pkg::CMD_OVERFLOW, 16'h0);
    for (int i = 0; i < 32; i++) add_item(citc_pkg::CMD_SAMPLE, 16'hFFFF);
    for (int i = 0; i < 30; i++) add_item(citc_pkg::CMD_TICK, 16'h0);
    drain();

    // Random phases, each under its own setting, the extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      configure((ph < 2) ? ph : 2);
      queued = 0;
      while (queued < 70) begin
        case ($urandom_range(0, 9))
          0: begin
            add_item(citc_pkg::CMD_OVERFLOW, 16'($urandom));
            queued++;
          end
          1: begin
            add_item(citc_pkg::CMD_NONE, 16'($urandom));
            queued++;
          end
          2, 3, 4: begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) add_item(citc_pkg::CMD_TICK, 16'($urandom));
            queued += n;
          end
          default: begin
            n = $urandom_range(1, 36);
            for (int i = 0; i < n; i++) add_item(citc_pkg::CMD_SAMPLE, pick_period());
            queued += n;
          end
        endcase
      end
      drain();
    end

    if (mismatches == 0 && coil_expect_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #12000000;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/citc_pkg.sv
hdl/citc_front.sv
hdl/citc_back.sv
hdl/cdi_ignition_timing_controller_core.sv
hdl/citc_checker.sv
verif/tb.sv
